FILE: hw/rtl/wrapped_grid_interpolating_sampler_defines.svh
// Assertion shorthands shared by the sampler's RTL.
`ifndef WRAPPED_GRID_INTERPOLATING_SAMPLER_DEFINES_SVH
`define WRAPPED_GRID_INTERPOLATING_SAMPLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WGIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WGIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/wgis_pkg.sv
package wgis_pkg;

  localparam int GRID_AW   = 6;            // log2 of the maximum grid side
  localparam int VAL_W     = 32;
  localparam int COORD_W   = 24;
  localparam int FRAC_W    = 8;
  localparam int INT_W     = COORD_W - FRAC_W;
  localparam int SIZE_W    = 7;
  localparam int MAX_SIDE  = 64;
  localparam int WQ_W      = 17;           // Q16 weight, 0..65536
  localparam int W8_W      = 8;            // corner weight in 1/255 units
  localparam int WSUM_W    = 10;
  localparam int ACC_W     = 43;
  localparam int DVD_W     = 44;
  localparam int STEP_W    = 4;

  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_COSINE = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MODE   = 2'd2;

  localparam logic [STEP_W-1:0] LAST_WRAP = 4'd3;
  localparam logic [STEP_W-1:0] LAST_TRD  = 4'd1;
  localparam logic [STEP_W-1:0] LAST_WGT  = 4'd4;
  localparam logic [STEP_W-1:0] LAST_MAC  = 4'd5;
  localparam logic [STEP_W-1:0] LAST_DIV  = 4'd11;

  typedef enum logic [2:0] {
    S_IDLE, S_WRAP, S_TRD, S_WGT, S_MAC, S_DIV, S_FIN, S_DONE
  } state_t;

  typedef struct packed {
    logic              load;
    logic              wr;
    logic              mod_step;
    logic              rd_en;
    logic [1:0]        rd_sel;
    logic              trunc_fin;
    logic              wgt_step;
    logic              mac_step;
    logic              div_init;
    logic              div_step;
    logic              div_fin;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic sample_op;
    logic interp;
    logic out_free;
  } sts_t;

  typedef logic [WQ_W-1:0] cos_tab_t [256];

  localparam logic [63:0] COS_C1  = 64'd1324675879;
  localparam logic [63:0] COS_C2  = 64'd272375577;
  localparam logic [63:0] COS_C3  = 64'd22401992;
  localparam logic [63:0] COS_C4  = 64'd987048;
  localparam logic [63:0] COS_C5  = 64'd27061;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // Quarter cosine in Q16, indexed by the coordinate fraction.
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t    t;
    logic [63:0] f16;
    logic [63:0] u;
    logic [63:0] p;
    for (int i = 0; i < 256; i++) begin
      f16  = 64'(i) << (16 - FRAC_W);
      u    = (f16 * f16) >> 2;
      p    = COS_C5;
      p    = COS_C4 - ((u * p) >> 30);
      p    = COS_C3 - ((u * p) >> 30);
      p    = COS_C2 - ((u * p) >> 30);
      p    = COS_C1 - ((u * p) >> 30);
      p    = ONE_Q30 - ((u * p) >> 30);
      t[i] = WQ_W'((p + 64'd8192) >> 14);
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

FILE: hw/rtl/wrapped_grid_interpolating_sampler.sv
// Wrapped-grid sampler: a 64 x 64 grid of signed 32-bit cells, row-major,
// wrapping in both axes at the programmed grid_width and grid_height. A write
// transaction stores one cell; the input is free again on the next edge and
// gives no result. A sample transaction wraps the integer part of each
// coordinate (8 fraction bits) as floor modulo the grid size, then either
// returns that cell (truncate mode) or blends the cell with its right, lower
// and lower-right neighbours using bilinear or quarter-cosine weights rounded
// to whole 1/255 units, dividing by the weight sum with truncation toward
// zero. Throughout a sample the input is stalled; its running time is set by
// the modulo unit, the single shared weight multiplier and grid read port (one
// corner a cycle), and the restoring divider, which retires 4 quotient bits a
// cycle over a 44-bit dividend. The result sits in an output register, so the
// next transaction can be accepted while it waits to be taken. Grid cells read
// before being written return undefined data. Configuration writes are never
// held off (cfg_ready is always high) and must only be issued while the block
// is idle.
`include "wrapped_grid_interpolating_sampler_defines.svh"

module wrapped_grid_interpolating_sampler (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_operation,
  input  logic [wgis_pkg::GRID_AW-1:0]           in_write_col,
  input  logic [wgis_pkg::GRID_AW-1:0]           in_write_row,
  input  logic signed [wgis_pkg::VAL_W-1:0]      in_write_value,
  input  logic signed [wgis_pkg::COORD_W-1:0]    in_sample_x,
  input  logic signed [wgis_pkg::COORD_W-1:0]    in_sample_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [wgis_pkg::VAL_W-1:0]      out_sample_value,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [1:0]                             cfg_index,
  input  logic [wgis_pkg::SIZE_W-1:0]            cfg_data
);
  import wgis_pkg::*;

  logic [SIZE_W-1:0] grid_width_r, grid_height_r;
  logic [1:0]        sample_mode_r;
  cmd_t              cmd;
  sts_t              sts;
  logic              out_free;

  assign cfg_ready = 1'b1;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= SIZE_W'(MAX_SIDE);
      grid_height_r <= SIZE_W'(MAX_SIDE);
      sample_mode_r <= MODE_LINEAR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  grid_width_r  <= cfg_data;
        CFG_HEIGHT: grid_height_r <= cfg_data;
        CFG_MODE:   sample_mode_r <= cfg_data[1:0];
        default:    sample_mode_r <= sample_mode_r;
      endcase
    end
  end

  // Only bilinear and cosine interpolate; the spare mode code truncates.
  assign sts.sample_op = in_operation;
  assign sts.interp    = (sample_mode_r == MODE_LINEAR) || (sample_mode_r == MODE_COSINE);
  assign sts.out_free  = out_free;

  wgis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wgis_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_write_col     (in_write_col),
    .in_write_row     (in_write_row),
    .in_write_value   (in_write_value),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .grid_width       (grid_width_r),
    .grid_height      (grid_height_r),
    .sample_mode      (sample_mode_r),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sample_value (out_sample_value),
    .out_free         (out_free)
  );

  // Never overwrite a result still waiting to be taken.
  `WGIS_ASSERT_NOW(a_no_overwrite, cmd.out_load, !(out_valid && out_stall), "result overwritten")
  // A loaded result is presented on the next cycle.
  `WGIS_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid, "loaded result not presented")
  // A write transaction leaves the input free.
  `WGIS_ASSERT_NEXT(a_write_free, in_valid && !in_stall && !in_operation, !in_stall, "write stalled input")
  // A sample transaction holds the input off while it is worked on.
  `WGIS_ASSERT_NEXT(a_sample_busy, in_valid && !in_stall && in_operation, in_stall, "sample not busy")

endmodule

FILE: hw/rtl/wgis_ctrl.sv
module wgis_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  wgis_pkg::sts_t  sts,
  output wgis_pkg::cmd_t  cmd
);
  import wgis_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 4'd1;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_valid && sts.sample_op) state_nxt = S_WRAP;
      end
      S_WRAP: begin
        if (step_r == LAST_WRAP) begin
          step_nxt  = '0;
          state_nxt = sts.interp ? S_WGT : S_TRD;
        end
      end
      S_TRD: begin
        if (step_r == LAST_TRD) begin
          step_nxt  = '0;
          state_nxt = S_DONE;
        end
      end
      S_WGT: begin
        if (step_r == LAST_WGT) begin
          step_nxt  = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (step_r == LAST_MAC) begin
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (step_r == LAST_DIV) begin
          step_nxt  = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        step_nxt  = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        step_nxt = '0;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        step_nxt  = '0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.step = step_r;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        cmd.wr   = in_valid && !sts.sample_op;
      end
      S_WRAP: cmd.mod_step = 1'b1;
      S_TRD: begin
        cmd.rd_en     = (step_r == '0);
        cmd.trunc_fin = (step_r == LAST_TRD);
      end
      S_WGT: cmd.wgt_step = 1'b1;
      S_MAC: begin
        cmd.mac_step = 1'b1;
        cmd.rd_en    = (step_r < 4'd4);
        cmd.rd_sel   = step_r[1:0];
      end
      S_DIV: begin
        cmd.div_init = (step_r == '0);
        cmd.div_step = (step_r != '0);
      end
      S_FIN:   cmd.div_fin  = 1'b1;
      S_DONE:  cmd.out_load = sts.out_free;
      default: cmd.load     = 1'b0;
    endcase
  end

endmodule

FILE: hw/rtl/wgis_dp.sv
module wgis_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  wgis_pkg::cmd_t                         cmd,
  input  logic [wgis_pkg::GRID_AW-1:0]           in_write_col,
  input  logic [wgis_pkg::GRID_AW-1:0]           in_write_row,
  input  logic signed [wgis_pkg::VAL_W-1:0]      in_write_value,
  input  logic signed [wgis_pkg::COORD_W-1:0]    in_sample_x,
  input  logic signed [wgis_pkg::COORD_W-1:0]    in_sample_y,
  input  logic [wgis_pkg::SIZE_W-1:0]            grid_width,
  input  logic [wgis_pkg::SIZE_W-1:0]            grid_height,
  input  logic [1:0]                             sample_mode,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic signed [wgis_pkg::VAL_W-1:0]      out_sample_value,
  output logic                                   out_free
);
  import wgis_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;

  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] v);
    if (v == '0) return SIZE_W'(1);
    if (v > SIZE_W'(MAX_SIDE)) return SIZE_W'(MAX_SIDE);
    return v;
  endfunction

  // Four restoring remainder steps, one bit each.
  function automatic logic [SIZE_W-1:0] mod_step4(logic [SIZE_W-1:0] r_in,
                                                  logic [3:0] nib,
                                                  logic [SIZE_W-1:0] d);
    logic [SIZE_W-1:0] r;
    r = r_in;
    for (int j = 3; j >= 0; j--) begin
      r = {r[SIZE_W-2:0], nib[j]};
      if (r >= d) r = r - d;
    end
    return r;
  endfunction

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_r;

  logic [SIZE_W-1:0] weff_r, heff_r, remx_r, remy_r;
  logic [INT_W-1:0]  magx_r, magy_r;
  logic              negx_r, negy_r;
  logic [WQ_W-1:0]   lx_r, ly_r;
  logic [2*WQ_W-1:0] prod_r;
  logic [W8_W-1:0]   w_r [4];
  logic signed [VAL_W+W8_W:0] mprod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [WSUM_W:0]   rem_r;
  logic [WSUM_W-1:0] wsum_r;
  logic              neg_r;
  logic signed [VAL_W-1:0] res_r;
  logic              out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;

  logic [INT_W-1:0]  intx, inty;
  logic [WQ_W-1:0]   lx_c, ly_c, hx, hy, op_a, op_b;
  logic [SIZE_W-1:0] x0, y0, x1, y1, rx, ry;
  logic [2*GRID_AW-1:0] rd_addr;
  logic [41:0]       wround;
  logic [1:0]        wi;
  logic [ACC_W-1:0]  acc_mag;
  logic [WSUM_W:0]   div_rem_c;
  logic [DVD_W-1:0]  div_dvd_c;
  logic [VAL_W-1:0]  quot;

  assign intx = in_sample_x[COORD_W-1:FRAC_W];
  assign inty = in_sample_y[COORD_W-1:FRAC_W];

  always_comb begin
    if (sample_mode == MODE_COSINE) begin
      lx_c = COS_TAB[in_sample_x[FRAC_W-1:0]];
      ly_c = COS_TAB[in_sample_y[FRAC_W-1:0]];
    end else begin
      lx_c = WQ_W'(65536) - WQ_W'({in_sample_x[FRAC_W-1:0], 8'b0});
      ly_c = WQ_W'(65536) - WQ_W'({in_sample_y[FRAC_W-1:0], 8'b0});
    end
  end

  // Floor modulo: fold the sign back in after the magnitude remainder.
  assign x0 = (negx_r && remx_r != '0) ? weff_r - remx_r : remx_r;
  assign y0 = (negy_r && remy_r != '0) ? heff_r - remy_r : remy_r;
  assign x1 = (x0 + 7'd1 == weff_r) ? '0 : x0 + 7'd1;
  assign y1 = (y0 + 7'd1 == heff_r) ? '0 : y0 + 7'd1;

  assign rx = cmd.rd_sel[0] ? x1 : x0;
  assign ry = cmd.rd_sel[1] ? y1 : y0;
  assign rd_addr = {ry[GRID_AW-1:0], rx[GRID_AW-1:0]};

  assign hx   = WQ_W'(65536) - lx_r;
  assign hy   = WQ_W'(65536) - ly_r;
  assign op_a = cmd.step[0] ? hx : lx_r;
  assign op_b = cmd.step[1] ? hy : ly_r;
  assign wi   = 2'(cmd.step - 4'd1);
  // x255 then round half up from 2^-32
  assign wround = ({prod_r, 8'b0} - {8'b0, prod_r}) + 42'h0_8000_0000;

  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  always_comb begin
    logic [WSUM_W:0]  r;
    logic [DVD_W-1:0] d;
    r = rem_r;
    d = dvd_r;
    for (int j = 0; j < 4; j++) begin
      r = {r[WSUM_W-1:0], d[DVD_W-1]};
      d = {d[DVD_W-2:0], 1'b0};
      if (r >= {1'b0, wsum_r}) begin
        r    = r - {1'b0, wsum_r};
        d[0] = 1'b1;
      end
    end
    div_rem_c = r;
    div_dvd_c = d;
  end

  assign quot = dvd_r[VAL_W-1:0];

  // Grid store
  always_ff @(posedge clk) begin
    if (cmd.wr) mem[{in_write_row, in_write_col}] <= in_write_value;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      weff_r <= eff_size(grid_width);
      heff_r <= eff_size(grid_height);
      negx_r <= intx[INT_W-1];
      negy_r <= inty[INT_W-1];
      magx_r <= intx[INT_W-1] ? INT_W'(-intx) : intx;
      magy_r <= inty[INT_W-1] ? INT_W'(-inty) : inty;
      remx_r <= '0;
      remy_r <= '0;
      lx_r   <= lx_c;
      ly_r   <= ly_c;
    end
    if (cmd.mod_step) begin
      remx_r <= mod_step4(remx_r, magx_r[INT_W-1 -: 4], weff_r);
      remy_r <= mod_step4(remy_r, magy_r[INT_W-1 -: 4], heff_r);
      magx_r <= {magx_r[INT_W-5:0], 4'b0};
      magy_r <= {magy_r[INT_W-5:0], 4'b0};
    end
    if (cmd.wgt_step) begin
      if (cmd.step < 4'd4) prod_r <= op_a * op_b;
      if (cmd.step != '0) w_r[wi] <= wround[39:32];
    end
    if (cmd.mac_step) begin
      if (cmd.step >= 4'd1 && cmd.step <= 4'd4) begin
        mprod_r <= rd_r * $signed({1'b0, w_r[wi]});
      end
      if (cmd.step == '0) acc_r <= '0;
      else if (cmd.step >= 4'd2) acc_r <= acc_r + ACC_W'(mprod_r);
    end
    if (cmd.div_init) begin
      neg_r  <= acc_r[ACC_W-1];
      dvd_r  <= {1'b0, acc_mag};
      rem_r  <= '0;
      wsum_r <= WSUM_W'(w_r[0]) + WSUM_W'(w_r[1]) + WSUM_W'(w_r[2]) + WSUM_W'(w_r[3]);
    end
    if (cmd.div_step) begin
      rem_r <= div_rem_c;
      dvd_r <= div_dvd_c;
    end
    if (cmd.trunc_fin) res_r <= rd_r;
    if (cmd.div_fin) begin
      if (wsum_r == '0) res_r <= '0;
      else              res_r <= neg_r ? VAL_W'(-quot) : VAL_W'(quot);
    end
    if (cmd.out_load) out_value_r <= res_r;
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_free         = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

endmodule

FILE: bench/wrapped_grid_interpolating_sampler_tb.sv
module wrapped_grid_interpolating_sampler_tb;
  import wgis_pkg::*;

  // Operation and mode codes not named by the package
  localparam logic       OP_WRITE   = 1'b0;
  localparam logic       OP_SAMPLE  = 1'b1;
  localparam logic [1:0] MODE_TRUNC = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_operation = OP_WRITE;
  logic [GRID_AW-1:0]         in_write_col = '0;
  logic [GRID_AW-1:0]         in_write_row = '0;
  logic signed [VAL_W-1:0]    in_write_value = '0;
  logic signed [COORD_W-1:0]  in_sample_x = '0;
  logic signed [COORD_W-1:0]  in_sample_y = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [VAL_W-1:0]    out_sample_value;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = CFG_WIDTH;
  logic [SIZE_W-1:0]          cfg_data = '0;

  wrapped_grid_interpolating_sampler dut (.*);

  always #5 clk = ~clk;

  // Shadow of the block: grid contents and the three registers
  logic signed [VAL_W-1:0] grid_shadow [MAX_SIDE*MAX_SIDE];
  logic [SIZE_W-1:0]       cols_reg = 7'd64;
  logic [SIZE_W-1:0]       rows_reg = 7'd64;
  logic [1:0]              mode_reg = MODE_LINEAR;

  logic signed [VAL_W-1:0] samples_due [$];
  int                      fail_count = 0;
  int                      send_idle_pct = 0;
  int                      stall_pct = 0;

  typedef struct {
    logic                      op;
    logic [GRID_AW-1:0]        col;
    logic [GRID_AW-1:0]        row;
    logic signed [VAL_W-1:0]   val;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
    logic [1:0]                mode;
    bit                        typed;
    logic signed [VAL_W-1:0]   expv;
  } stim_row_t;

  // Directed rows: extremes, every mode, size clamping, negative wrap.
  // Grid size and mode columns apply to sample rows only.
  stim_row_t directed_rows [20] = '{
    '{OP_WRITE, 6'd0, 6'd0, 32'sh80000000, 0, 0, 64, 64, MODE_LINEAR, 0, 0},
    '{OP_WRITE, 6'd63, 6'd63, 32'sh7fffffff, 0, 0, 64, 64, MODE_LINEAR, 0, 0},
    '{OP_WRITE, 6'd1, 6'd0, 32'sd100, 0, 0, 64, 64, MODE_LINEAR, 0, 0},
    '{OP_WRITE, 6'd0, 6'd1, 32'sd200, 0, 0, 64, 64, MODE_LINEAR, 0, 0},
    '{OP_WRITE, 6'd1, 6'd1, 32'sd300, 0, 0, 64, 64, MODE_LINEAR, 0, 0},
    '{OP_SAMPLE, 0, 0, 0, 24'sd0, 24'sd0, 64, 64, MODE_LINEAR, 1, 32'sh80000000},
    '{OP_SAMPLE, 0, 0, 0, -24'sd256, -24'sd256, 64, 64, MODE_LINEAR, 1, 32'sh7fffffff},
    '{OP_SAMPLE, 0, 0, 0, 24'sh7fffff, 24'sh7fffff, 64, 64, MODE_LINEAR, 0, 0},
    '{OP_SAMPLE, 0, 0, 0, 24'sh800000, 24'sh800000, 64, 64, MODE_LINEAR, 0, 0},
    '{OP_SAMPLE, 0, 0, 0, 24'sd128, 24'sd128, 64, 64, MODE_LINEAR, 0, 0},
    '{OP_SAMPLE, 0, 0, 0, 24'sd128, 24'sd128, 64, 64, MODE_COSINE, 0, 0},
    '{OP_SAMPLE, 0, 0, 0, 24'sd255, 24'sd255, 64, 64, MODE_TRUNC, 1, 32'sh80000000},
    '{OP_SAMPLE, 0, 0, 0, 24'sd256, 24'sd256, 64, 64, MODE_SPARE, 1, 32'sd300},
    '{OP_SAMPLE, 0, 0, 0, 24'sd25677, -24'sd5, 0, 0, MODE_LINEAR, 1, 32'sh80000000},
    '{OP_SAMPLE, 0, 0, 0, -24'sd256, 24'sd0, 127, 127, MODE_LINEAR, 0, 0},
    '{OP_SAMPLE, 0, 0, 0, 24'sd832, 24'sd456, 1, 64, MODE_COSINE, 0, 0},
    '{OP_SAMPLE, 0, 0, 0, 24'sd300, -24'sd700, 64, 1, MODE_LINEAR, 0, 0},
    '{OP_WRITE, 6'd2, 6'd3, 32'sd0, 0, 0, 64, 64, MODE_LINEAR, 0, 0},
    '{OP_SAMPLE, 0, 0, 0, 24'sd512, 24'sd768, 64, 64, MODE_LINEAR, 1, 32'sd0},
    '{OP_SAMPLE, 0, 0, 0, -24'sd1, -24'sd1, 64, 64, MODE_COSINE, 0, 0}
  };

  // Quarter cosine in Q16 by Horner evaluation in Q30
  function automatic longint unsigned cos_q16(longint unsigned f16);
    longint unsigned u;
    longint unsigned p;
    u = (f16 * f16) >> 2;
    p = 64'd27061;
    p = 64'd987048 - ((u * p) >> 30);
    p = 64'd22401992 - ((u * p) >> 30);
    p = 64'd272375577 - ((u * p) >> 30);
    p = 64'd1324675879 - ((u * p) >> 30);
    p = 64'd1073741824 - ((u * p) >> 30);
    return (p + 64'd8192) >> 14;
  endfunction

  function automatic longint unsigned weight_255(longint unsigned a, longint unsigned b);
    return (a * b * 64'd255 + 64'd2147483648) >> 32;
  endfunction

  function automatic int eff_side(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic int floor_mod(longint v, int n);
    longint r;
    r = v % n;
    if (r < 0) r += n;
    return int'(r);
  endfunction

  function automatic longint grid_at(int col, int row);
    return longint'(grid_shadow[row * MAX_SIDE + col]);
  endfunction

  function automatic logic signed [VAL_W-1:0] sample_value(logic signed [COORD_W-1:0] x,
                                                          logic signed [COORD_W-1:0] y);
    int              w, h, x0, x1, y0, y1;
    longint          fx, fy, acc;
    longint unsigned fx16, fy16, lx, ly, hx, hy, w00, w10, w01, w11, wsum;
    w  = eff_side(cols_reg);
    h  = eff_side(rows_reg);
    fx = longint'(x >>> FRAC_W);
    fy = longint'(y >>> FRAC_W);
    x0 = floor_mod(fx, w);
    y0 = floor_mod(fy, h);
    if (mode_reg != MODE_LINEAR && mode_reg != MODE_COSINE) return VAL_W'(grid_at(x0, y0));
    x1   = floor_mod(fx + 1, w);
    y1   = floor_mod(fy + 1, h);
    fx16 = longint'(x[FRAC_W-1:0]) << (16 - FRAC_W);
    fy16 = longint'(y[FRAC_W-1:0]) << (16 - FRAC_W);
    if (mode_reg == MODE_LINEAR) begin
      lx = 65536 - fx16;
      ly = 65536 - fy16;
    end else begin
      lx = cos_q16(fx16);
      ly = cos_q16(fy16);
    end
    hx   = 65536 - lx;
    hy   = 65536 - ly;
    w00  = weight_255(lx, ly);
    w10  = weight_255(hx, ly);
    w01  = weight_255(lx, hy);
    w11  = weight_255(hx, hy);
    wsum = w00 + w10 + w01 + w11;
    acc  = grid_at(x0, y0) * longint'(w00) + grid_at(x1, y0) * longint'(w10)
         + grid_at(x0, y1) * longint'(w01) + grid_at(x1, y1) * longint'(w11);
    if (wsum == 0) return '0;
    return VAL_W'(acc / longint'(wsum));
  endfunction

  task automatic report_mismatch(string what, logic signed [VAL_W-1:0] want,
                                 logic signed [VAL_W-1:0] got);
    $display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    fail_count++;
  endtask

  // Offer one transaction, hold it until taken, then perhaps idle
  task automatic drive_item(logic op, logic [GRID_AW-1:0] col, logic [GRID_AW-1:0] row,
                            logic signed [VAL_W-1:0] val, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y, bit typed,
                            logic signed [VAL_W-1:0] typed_val);
    int gap;
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_write_col   <= col;
    in_write_row   <= row;
    in_write_value <= val;
    in_sample_x    <= x;
    in_sample_y    <= y;
    do @(posedge clk); while (in_stall);
    if (op == OP_WRITE) grid_shadow[row * MAX_SIDE + col] = val;
    else samples_due.push_back(typed ? typed_val : sample_value(x, y));
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain every outstanding sample, then let the datapath settle
  task automatic drain();
    in_valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [SIZE_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDTH:  cols_reg = data;
      CFG_HEIGHT: rows_reg = data;
      default:    mode_reg = data[1:0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic [1:0] m);
    if (w != cols_reg) write_reg(CFG_WIDTH, w);
    if (h != rows_reg) write_reg(CFG_HEIGHT, h);
    if (m != mode_reg) write_reg(CFG_MODE, {5'd0, m});
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int kind;
    kind = $urandom_range(9);
    if (kind == 0) return COORD_W'($urandom);
    if (kind == 1) return $urandom_range(1) ? 24'sh800000 : 24'sh7fffff;
    return COORD_W'(int'($urandom_range(0, 20480)) - 10240);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(7))
      0:       return 32'sh80000000;
      1:       return 32'sh7fffffff;
      2:       return VAL_W'(int'($urandom_range(0, 2000)) - 1000);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Receiver: stall at random according to the current phase
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Check each result taken against the oldest pending sample
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (samples_due.size() == 0) begin
        report_mismatch("unexpected result", 'x, out_sample_value);
      end else begin
        if (out_sample_value !== samples_due[0])
          report_mismatch("sample_value", samples_due[0], out_sample_value);
        void'(samples_due.pop_front());
      end
    end
  end

  logic [SIZE_W-1:0] side_picks [6] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd63};
  // Random heights stay within the filled rows 0 to 3
  logic [SIZE_W-1:0] row_picks [6]  = '{7'd4, 7'd1, 7'd0, 7'd3, 7'd2, 7'd4};

  initial begin
    int chunk;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill rows 0 to 3 and the last row in full; with heights of at most
    // four in the random part, no sample ever reads an unwritten cell
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < MAX_SIDE; c++)
        drive_item(OP_WRITE, GRID_AW'(c), (r == 4) ? GRID_AW'(MAX_SIDE - 1) : GRID_AW'(r),
                   VAL_W'($urandom), 0, 0, 0, 0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == OP_SAMPLE)
        apply_setting(directed_rows[i].w, directed_rows[i].h, directed_rows[i].mode);
      drive_item(directed_rows[i].op, directed_rows[i].col, directed_rows[i].row,
                 directed_rows[i].val, directed_rows[i].x, directed_rows[i].y,
                 directed_rows[i].typed, directed_rows[i].expv);
    end

    // Random part: chunks of 26 transactions, each with its own setting
    // and idling phase; mode advances out of step with the phase
    for (chunk = 0; chunk < 8; chunk++) begin
      drain();
      case (chunk % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      if (chunk < 6)
        apply_setting(side_picks[chunk], row_picks[chunk], 2'((chunk + chunk / 4) % 4));
      else
        apply_setting(SIZE_W'($urandom_range(1, 64)), SIZE_W'($urandom_range(0, 4)),
                      2'((chunk + chunk / 4) % 4));
      repeat (26) begin
        if ($urandom_range(1))
          drive_item(OP_WRITE, GRID_AW'($urandom), GRID_AW'($urandom), rand_value(),
                     rand_coord(), rand_coord(), 0, 0);
        else
          drive_item(OP_SAMPLE, GRID_AW'($urandom), GRID_AW'($urandom), rand_value(),
                     rand_coord(), rand_coord(), 0, 0);
      end
    end

    drain();
    if (fail_count == 0)
      $display("wrapped_grid_interpolating_sampler regression: pass");
    else
      $display("wrapped_grid_interpolating_sampler regression: fail");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3000000;
    $display("wrapped_grid_interpolating_sampler regression: fail");
    $finish;
  end

endmodule
